// File: rtl/crossbar_store_dma_device_macros.svh
// Assertion macros for the crossbar store DMA device RTL.
`ifndef CROSSBAR_STORE_DMA_DEVICE_MACROS_SVH
`define CROSSBAR_STORE_DMA_DEVICE_MACROS_SVH

// Same-cycle implication under active-low reset.
`define CBSD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under active-low reset.
`define CBSD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cbsd_pkg.sv
// Shared types and constants of the crossbar store DMA device.
package cbsd_pkg;

  localparam int unsigned MAX_ROWS      = 256;
  localparam int unsigned MAX_ROW_BYTES = 64;
  localparam int unsigned STORE_DEPTH   = MAX_ROWS * MAX_ROW_BYTES;
  localparam int unsigned STORE_AW      = $clog2(STORE_DEPTH);

  localparam int unsigned ROWS_W   = 9;
  localparam int unsigned RBYTES_W = 7;
  localparam int unsigned BEAT_W   = 15;
  localparam int unsigned LEN_W    = 15;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;

  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 80;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES = 1'b1;

  typedef enum logic [1:0] {
    MODE_RD  = 2'd0,
    MODE_WR  = 2'd1,
    MODE_DMA = 2'd2,
    MODE_NOP = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_CONF   = 3'd0,
    REG_MADDR  = 3'd1,
    REG_ROW    = 3'd2,
    REG_LEN    = 3'd3,
    REG_MULT   = 3'd4,
    REG_STATUS = 3'd5,
    REG_CTRL   = 3'd6,
    REG_NONE   = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic        start;
    logic [LEN_W-1:0]    dividend;
    logic [RBYTES_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic [31:0] rd;
    logic        valid;
    logic        to_mem;
    logic [31:0] addr;
    logic        last;
    logic        use_store;
    logic        scale;
    logic [7:0]  mul;
  } stage_t;

endpackage

// File: rtl/crossbar_store_dma_device.sv
// Crossbar store DMA device: register bus, row command engine and byte store.
// After reset the 16384-byte store is cleared one byte per cycle, and no item
// is taken until the clear pass ends; configuration writes are taken at any
// time. Register accesses and DMA beats then go at one item per cycle when the
// output is not stalled, each result going through a store read and then the
// output register. A control write that starts a command holds off input
// while the serial remainder unit checks the length against the row width,
// one dividend bit per cycle.
`include "crossbar_store_dma_device_macros.svh"

module crossbar_store_dma_device (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // cfg: 0 row_count, 1 row_bytes
  input  logic                                cfg_we_i,
  input  logic [cbsd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cbsd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // reg_index[2:0], write_value[34:3], dma_byte_in[42:35], zero pad
  input  logic [cbsd_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // mode[1:0]
  input  logic [cbsd_pkg::S_TUSER_W-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // read_data[31:0], dma_valid[32], dma_to_memory[33], dma_addr[65:34],
  // dma_byte_out[73:66], zero pad
  output logic [cbsd_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tlast
);
  import cbsd_pkg::*;

  state_e state_q, state_d;
  logic [STORE_AW-1:0] clr_addr_q, clr_addr_d;

  logic [ROWS_W-1:0]   row_count_q, row_count_d;
  logic [RBYTES_W-1:0] row_bytes_q, row_bytes_d;
  logic [31:0] mem_base_q, mem_base_d;
  logic [31:0] row_sel_q, row_sel_d;
  logic [31:0] xfer_len_q, xfer_len_d;
  logic [31:0] mult_q, mult_d;
  logic busy_q, busy_d, wtype_q, wtype_d, comp_q, comp_d, err_q, err_d;
  logic pend_err_q, pend_err_d;
  logic [BEAT_W-1:0] beat_q, beat_d;

  stage_t s1_q, s1_d;
  logic   s1_valid_q, s1_valid_d;
  logic [M_TDATA_W-1:0] out_data_q, out_data_d;
  logic out_last_q, out_last_d, out_valid_q, out_valid_d;

  mode_e mode;
  reg_e  reg_idx;
  logic [31:0] wval;
  logic [7:0]  din;

  logic in_rdy, clearing, acc, s1_move, beat_go, cmd_start;
  logic [BEAT_W-1:0]   base;
  logic [BEAT_W:0]     idx, beat_nx;
  logic                in_store, last_beat;
  logic [15:0]         span;
  logic                row_bad, range_bad;
  logic [RBYTES_W-1:0] rbytes_clamp;
  logic [ROWS_W-1:0]   rows_clamp;

  logic ram_we, ram_re;
  logic [STORE_AW-1:0] ram_waddr;
  logic [7:0] ram_wdata, ram_rdata;
  logic [15:0] prod;
  logic [7:0]  byte_out;

  rem_req_t rem_req;
  logic rem_done;
  logic [RBYTES_W-1:0] rem_val;

  assign mode    = mode_e'(s_axis_tuser[1:0]);
  assign reg_idx = reg_e'(s_axis_tdata[2:0]);
  assign wval    = s_axis_tdata[34:3];
  assign din     = s_axis_tdata[42:35];

  assign s1_move = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign acc     = s_axis_tvalid && in_rdy;
  assign beat_go = (mode == MODE_DMA) && busy_q;
  assign cmd_start = acc && (mode == MODE_WR) && (reg_idx == REG_CTRL) && !busy_q;

  assign base      = BEAT_W'(row_sel_q[7:0] * row_bytes_q);
  assign idx       = {1'b0, base} + {1'b0, beat_q};
  assign in_store  = (idx[BEAT_W:STORE_AW] == '0);
  assign beat_nx   = {1'b0, beat_q} + 1'b1;
  assign last_beat = {16'd0, beat_nx} >= xfer_len_q;
  assign span      = 16'(row_count_q * row_bytes_q);
  assign row_bad   = row_sel_q >= {23'd0, row_count_q};
  assign range_bad = ({18'd0, base} + {1'b0, xfer_len_q}) > {17'd0, span};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_addr_q == STORE_AW'(STORE_DEPTH - 1)) state_d = ST_RUN;
      ST_RUN:   if (cmd_start) state_d = ST_DIV;
      ST_DIV:   if (rem_done) state_d = ST_RUN;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // State outputs.
  always_comb begin
    clearing = 1'b0;
    in_rdy   = 1'b0;
    case (state_q)
      ST_CLEAR: clearing = 1'b1;
      ST_RUN:   in_rdy   = !s1_valid_q || s1_move;
      ST_DIV:   in_rdy   = 1'b0;
      default:  clearing = 1'b0;
    endcase
  end

  assign clr_addr_d = clearing ? clr_addr_q + 1'b1 : clr_addr_q;

  assign rem_req.start    = cmd_start;
  assign rem_req.dividend = xfer_len_q[LEN_W-1:0];
  assign rem_req.divisor  = row_bytes_q;

  cbsd_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .done_o (rem_done),
    .rem_o  (rem_val)
  );

  assign ram_we    = clearing || (acc && beat_go && wtype_q && in_store);
  assign ram_waddr = clearing ? clr_addr_q : idx[STORE_AW-1:0];
  assign ram_wdata = clearing ? 8'd0 : din;
  assign ram_re    = acc && beat_go && !wtype_q && in_store;

  cbsd_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx[STORE_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    rows_clamp = cfg_data_i[ROWS_W-1:0];
    if (rows_clamp == '0) begin
      rows_clamp = ROWS_W'(1);
    end else if (rows_clamp > ROWS_W'(MAX_ROWS)) begin
      rows_clamp = ROWS_W'(MAX_ROWS);
    end
    rbytes_clamp = cfg_data_i[RBYTES_W-1:0];
    if (rbytes_clamp == '0) begin
      rbytes_clamp = RBYTES_W'(1);
    end else if (rbytes_clamp > RBYTES_W'(MAX_ROW_BYTES)) begin
      rbytes_clamp = RBYTES_W'(MAX_ROW_BYTES);
    end
  end

  // Register file, command engine and first stage.
  always_comb begin
    row_count_d = row_count_q;
    row_bytes_d = row_bytes_q;
    mem_base_d  = mem_base_q;
    row_sel_d   = row_sel_q;
    xfer_len_d  = xfer_len_q;
    mult_d      = mult_q;
    busy_d      = busy_q;
    wtype_d     = wtype_q;
    comp_d      = comp_q;
    err_d       = err_q;
    pend_err_d  = pend_err_q;
    beat_d      = beat_q;
    s1_d        = s1_q;
    s1_valid_d  = s1_move ? 1'b0 : s1_valid_q;

    if (cfg_we_i) begin
      if (cfg_index_i == CFG_ROW_COUNT) begin
        row_count_d = rows_clamp;
      end else begin
        row_bytes_d = rbytes_clamp;
      end
    end

    if (state_q == ST_DIV && rem_done) begin
      if (pend_err_q || (!comp_q && rem_val != '0)) begin
        err_d = 1'b1;
      end else begin
        busy_d = (xfer_len_q != '0);
      end
    end

    if (acc) begin
      s1_valid_d = 1'b1;
      s1_d       = '0;
      s1_d.mul   = mult_q[7:0];
      case (mode)
        MODE_RD: begin
          case (reg_idx)
            REG_CONF:   s1_d.rd = {7'd0, row_count_q, 9'd0, row_bytes_q};
            REG_MADDR:  s1_d.rd = mem_base_q;
            REG_ROW:    s1_d.rd = row_sel_q;
            REG_LEN:    s1_d.rd = xfer_len_q;
            REG_MULT:   s1_d.rd = mult_q;
            REG_STATUS: s1_d.rd = {29'd0, err_q, wtype_q, busy_q};
            default:    s1_d.rd = '0;
          endcase
        end
        MODE_WR: begin
          case (reg_idx)
            REG_MADDR: if (!busy_q) mem_base_d = wval;
            REG_ROW:   if (!busy_q) row_sel_d  = wval;
            REG_LEN:   if (!busy_q) xfer_len_d = wval;
            REG_MULT:  if (!busy_q) mult_d     = wval;
            REG_CTRL: begin
              if (busy_q) begin
                err_d = 1'b1;
              end else begin
                err_d      = 1'b0;
                comp_d     = wval[1];
                wtype_d    = wval[0] && !wval[1];
                beat_d     = '0;
                pend_err_d = row_bad || range_bad;
              end
            end
            default: ;
          endcase
        end
        MODE_DMA: begin
          if (busy_q) begin
            s1_d.valid     = 1'b1;
            s1_d.addr      = mem_base_q + {17'd0, beat_q};
            s1_d.to_mem    = !wtype_q;
            s1_d.scale     = comp_q;
            s1_d.use_store = !wtype_q && in_store &&
                             (!comp_q || beat_q < {8'd0, row_bytes_q});
            if (last_beat) begin
              s1_d.last = 1'b1;
              busy_d    = 1'b0;
              beat_d    = '0;
            end else begin
              beat_d = beat_nx[BEAT_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output register.
  assign prod     = ram_rdata * s1_q.mul;
  assign byte_out = s1_q.use_store ? (s1_q.scale ? prod[7:0] : ram_rdata) : 8'd0;

  always_comb begin
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_data_d  = {6'd0, byte_out, s1_q.addr, s1_q.to_mem, s1_q.valid, s1_q.rd};
      out_last_d  = s1_q.last;
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      row_count_q <= ROWS_W'(MAX_ROWS);
      row_bytes_q <= RBYTES_W'(MAX_ROW_BYTES);
      mem_base_q  <= '0;
      row_sel_q   <= '0;
      xfer_len_q  <= '0;
      mult_q      <= '0;
      busy_q      <= 1'b0;
      wtype_q     <= 1'b0;
      comp_q      <= 1'b0;
      err_q       <= 1'b0;
      pend_err_q  <= 1'b0;
      beat_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      row_count_q <= row_count_d;
      row_bytes_q <= row_bytes_d;
      mem_base_q  <= mem_base_d;
      row_sel_q   <= row_sel_d;
      xfer_len_q  <= xfer_len_d;
      mult_q      <= mult_d;
      busy_q      <= busy_d;
      wtype_q     <= wtype_d;
      comp_q      <= comp_d;
      err_q       <= err_d;
      pend_err_q  <= pend_err_d;
      beat_q      <= beat_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q       <= s1_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready = in_rdy;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  `CBSD_ASSERT_NXT(a_last_ends_xfer, clk_i, rst_ni,
    acc && beat_go && last_beat, !busy_q, "last beat must clear busy")
  `CBSD_ASSERT_NOW(a_no_store_write_in_div, clk_i, rst_ni,
    state_q == ST_DIV, !ram_we, "store write during command check")
  `CBSD_ASSERT_NOW(a_rem_done_in_div, clk_i, rst_ni,
    rem_done, state_q == ST_DIV, "remainder done outside command check")
  `CBSD_ASSERT_NOW(a_no_read_while_clear, clk_i, rst_ni,
    clearing, !ram_re, "store read during clear pass")

endmodule

// File: rtl/cbsd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module cbsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/cbsd_rem.sv
// Bit-serial remainder unit: transfer length modulo row width.
module cbsd_rem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbsd_pkg::rem_req_t req_i,
  output logic              done_o,
  output logic [cbsd_pkg::RBYTES_W-1:0] rem_o
);
  import cbsd_pkg::*;

  localparam int unsigned CNT_W = $clog2(LEN_W);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [LEN_W-1:0]    dvd_q, dvd_d;
  logic [RBYTES_W-1:0] dsr_q, dsr_d;
  logic [RBYTES_W-1:0] rem_q, rem_d;
  logic [RBYTES_W:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[LEN_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[LEN_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = RBYTES_W'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[RBYTES_W-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(LEN_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
